@@ design/b64_pkg.sv @@
// b64_pkg: shared types, constants and character mapping functions
// for the streaming base64 codec. No dependencies.
`timescale 1ns / 1ps

package b64_pkg;

  // Operating mode, written through the configuration channel
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);
  localparam logic [7:0]  PadChar    = 8'h3D;  // '='

  // One result transaction
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } res_t;

  // All results produced by one input item
  typedef struct packed {
    logic [ResCntW-1:0]         num;
    res_t [MaxResults-1:0]      res;
  } batch_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (w < 8'd26) begin
      return w + 8'h41;           // 'A'
    end else if (w < 8'd52) begin
      return w - 8'd26 + 8'h61;   // 'a'
    end else if (w < 8'd62) begin
      return w - 8'd52 + 8'h30;   // '0'
    end else if (w == 8'd62) begin
      return 8'h2B;               // '+'
    end else begin
      return 8'h2F;               // '/'
    end
  endfunction

  // Character to {valid, 6-bit value}; anything outside the alphabet is invalid
  function automatic logic [6:0] dec_char(logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      return {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      return {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      return {1'b1, t[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end else begin
      return {1'b0, t[5:0]};
    end
  endfunction

endpackage

@@ design/b64_core.sv @@
// b64_core: per-item encode/decode step and the stream state registers.
// Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  b64_pkg::mode_e   mode_i,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  output b64_pkg::batch_t  batch_o
);
  import b64_pkg::*;

  // Encode state
  logic [15:0] pend_q, pend_d;
  logic [1:0]  pcnt_q, pcnt_d;
  // Decode state
  logic [6:0]  resid_q, resid_d;
  logic [2:0]  rbits_q, rbits_d;

  batch_t     enc_batch, dec_batch;

  // Encode: gather three bytes, flush with padding on message end
  logic [1:0]  cnt;
  logic [15:0] npend;
  logic [23:0] ev;
  always_comb begin
    enc_batch = '0;
    pend_d    = pend_q;
    pcnt_d    = pcnt_q;
    cnt       = (pcnt_q == 2'd3) ? 2'd2 : pcnt_q;
    npend     = (cnt == 2'd0) ? {byte_i, 8'h00} : {pend_q[15:8], byte_i};
    ev        = (cnt == 2'd2) ? {pend_q, byte_i} : {npend, 8'h00};
    enc_batch.res[0] = '{data: enc_char(ev[23:18]), has_data: 1'b1, last: 1'b0};
    enc_batch.res[1] = '{data: enc_char(ev[17:12]), has_data: 1'b1, last: 1'b0};
    enc_batch.res[2] = '{data: enc_char(ev[11:6]),  has_data: 1'b1, last: 1'b0};
    enc_batch.res[3] = '{data: enc_char(ev[5:0]),   has_data: 1'b1, last: end_i};
    if (cnt == 2'd2) begin
      enc_batch.num = ResCntW'(MaxResults);
      pend_d        = '0;
      pcnt_d        = '0;
    end else if (!end_i) begin
      enc_batch.num = '0;
      pend_d        = npend;
      pcnt_d        = cnt + 2'd1;
    end else begin
      // one or two bytes left: pad to four characters
      if (cnt == 2'd0) begin
        enc_batch.res[2].data = PadChar;
      end
      enc_batch.res[3].data = PadChar;
      enc_batch.num         = ResCntW'(MaxResults);
      pend_d                = '0;
      pcnt_d                = '0;
    end
  end

  // Decode: shift in six bits per valid character, emit a byte per eight
  logic [6:0]  dc;
  logic [12:0] msk_in, vin, msk_out;
  logic [3:0]  nb, nb2;
  logic        emit;
  always_comb begin
    dec_batch = '0;
    dc        = dec_char(byte_i);
    msk_in    = (13'd1 << rbits_q) - 13'd1;
    vin       = {(resid_q & msk_in[6:0]), dc[5:0]};
    nb        = {1'b0, rbits_q} + 4'd6;
    emit      = nb >= 4'd8;
    nb2       = emit ? (nb - 4'd8) : nb;
    msk_out   = (13'd1 << nb2) - 13'd1;
    resid_d   = resid_q;
    rbits_d   = rbits_q;
    dec_batch.res[0] = '{data: 8'(vin >> nb2), has_data: 1'b1, last: end_i};
    if (dc[6]) begin
      resid_d = 7'(vin & msk_out);
      rbits_d = nb2[2:0];
      if (emit) begin
        dec_batch.num = ResCntW'(1);
      end
    end
    if (end_i) begin
      if (!(dc[6] && emit)) begin
        // bare end marker
        dec_batch.res[0] = '{data: 8'h00, has_data: 1'b0, last: 1'b1};
        dec_batch.num    = ResCntW'(1);
      end
      resid_d = '0;
      rbits_d = '0;
    end
  end

  assign batch_o = (mode_i == MODE_DECODE) ? dec_batch : enc_batch;

  // Stream state, updated only when an item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      pcnt_q  <= '0;
      resid_q <= '0;
      rbits_q <= '0;
    end else if (step_i) begin
      if (mode_i == MODE_DECODE) begin
        resid_q <= resid_d;
        rbits_q <= rbits_d;
      end else begin
        pend_q  <= pend_d;
        pcnt_q  <= pcnt_d;
      end
    end
  end

endmodule

@@ design/b64_outbuf.sv @@
// b64_outbuf: result register that holds one item's results and hands
// them out one transaction per cycle while pop_i is high. Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  b64_pkg::batch_t  batch_i,
  input  logic             pop_i,
  output logic             can_load_o,
  output logic             valid_o,
  output b64_pkg::res_t    head_o
);
  import b64_pkg::*;

  res_t [MaxResults-1:0] ent_q;
  logic [ResCntW-1:0]    cnt_q;

  assign valid_o    = cnt_q != '0;
  assign head_o     = ent_q[0];
  // Free now, or freed by the last entry leaving this cycle
  assign can_load_o = (cnt_q == '0) || (cnt_q == ResCntW'(1) && pop_i);

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= batch_i.num;
    end else if (pop_i) begin
      cnt_q <= cnt_q - ResCntW'(1);
    end
  end

  // Entries shift toward the head as results are taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= batch_i.res;
    end else if (pop_i) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
    end
  end

endmodule

@@ design/base64_codec.sv @@
// base64_codec: top level of the streaming base64 codec.
// Depends on b64_pkg, b64_core and b64_outbuf.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries data_byte_i and
//   msg_end_i. Output channel (out_valid_o / out_stall_i) carries
//   out_byte_o, has_data_o and out_last_o, one result per transaction.
//   The config channel (cfg_valid_i / cfg_ready_o, always ready) writes
//   the mode bit: 0 encodes bytes, 1 decodes characters. Change it only
//   while no item or result is in flight.
// Timing:
//   An accepted item is held in the input register until the result
//   register can take it, then is processed into the result register,
//   which offers its results. The result register hands out one result
//   per cycle while the receiver does not stall, so an encode group of
//   three bytes gives four output transactions, and decoding takes one
//   character per cycle while not stalled. A new item is taken only when
//   the result register is empty or its last result is leaving.
// Stall and reset:
//   While the receiver stalls, the result register holds and the input
//   register fills, after which in_stall_o rises. Reset clears the mode to
//   encode, empties both registers and clears all stream state.
`timescale 1ns / 1ps

module base64_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       msg_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_data_o,
  output logic       out_last_o
);
  import b64_pkg::*;

  mode_e      mode_q;
  logic       item_valid_q;
  logic [7:0] item_byte_q;
  logic       item_end_q;
  logic       can_load, step, pop, in_acc;
  batch_t     batch;
  res_t       head;

  assign cfg_ready_o = 1'b1;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // Input register; refills in the cycle it is drained
  assign step       = item_valid_q && can_load;
  assign in_stall_o = item_valid_q && !step;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_acc) begin
      item_valid_q <= 1'b1;
    end else if (step) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_byte_q <= data_byte_i;
      item_end_q  <= msg_end_i;
    end
  end

  b64_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .mode_i  (mode_q),
    .byte_i  (item_byte_q),
    .end_i   (item_end_q),
    .batch_o (batch)
  );

  assign pop = out_valid_o && !out_stall_i;

  b64_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .batch_i    (batch),
    .pop_i      (pop),
    .can_load_o (can_load),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  assign out_byte_o = head.data;
  assign has_data_o = head.has_data;
  assign out_last_o = head.last;

  // A bare end marker always closes a message and carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> out_last_o && out_byte_o == 8'h00)
    else $error("bare end marker malformed");

  // Encoding never produces a bare end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q == MODE_ENCODE |-> has_data_o)
    else $error("encode result without data");

  // Input is stalled only while an item waits on a busy result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid_q && out_valid_o)
    else $error("input stalled without backlog");

endmodule
